// ===== design/tdpb_pkg.sv =====
package tdpb_pkg;

  localparam int ARR_W  = 32;
  localparam int PROC_W = 16;
  localparam int SIZE_W = 11;
  localparam int TIME_W = 48;

  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef logic [TIME_W-1:0] stamp_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== design/tail_drop_packet_buffer_top.sv =====
// Channel   Ports                                        Transfer
// input     start, busy, in_arrive_tick, in_work_ticks   start high while busy is low
// result    out_valid, out_dropped, out_begin_tick       out_valid high for one cycle
// config    cfg_we, cfg_data                             cfg_we high at a clock edge
//
// Busy stays high through a retire step for each finish time freed, then a decision step.
// The row of cells retires one entry a cycle from its head.
// The result is strobed in the first cycle with busy low; a start held high
// is taken at the edge that ends that cycle.
// Reset is synchronous and clears the fill count; the cells themselves are not cleared.
// The receiver cannot stall, so no result is ever held back.
module tail_drop_packet_buffer_top #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tdpb_pkg::ARR_W-1:0]        in_arrive_tick,
  input  logic [tdpb_pkg::PROC_W-1:0]       in_work_ticks,
  input  logic                              cfg_we,
  input  logic [tdpb_pkg::SIZE_W-1:0]       cfg_data,
  output logic                              out_valid,
  output logic                              out_dropped,
  output logic [tdpb_pkg::TIME_W-1:0]       out_begin_tick
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tdpb_pkg::cell_ctl_t cell_ctl;
  logic [IDX_W-1:0]    load_idx;
  tdpb_pkg::stamp_t    load_data;
  tdpb_pkg::stamp_t    cell_q [DEPTH];

  tdpb_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .arrive_tick    (in_arrive_tick),
    .work_ticks     (in_work_ticks),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .head_q         (cell_q[0]),
    .cell_ctl       (cell_ctl),
    .load_idx       (load_idx),
    .load_data      (load_data),
    .out_valid      (out_valid),
    .out_dropped    (out_dropped),
    .out_begin_tick (out_begin_tick)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tdpb_pkg::stamp_t right;
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_q[i + 1];
    end
    tdpb_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .sel        (load_idx == IDX_W'(i)),
      .load_data  (load_data),
      .right_data (right),
      .q          (cell_q[i])
    );
  end

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a packet in progress");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted packet did not raise busy");

  a_drop_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_begin_tick == '0))
    else $error("dropped packet carries a non-zero start tick");

  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("packet finished without a result strobe");

endmodule

// ===== design/tdpb_cell.sv =====
module tdpb_cell (
  input  logic                clk,
  input  tdpb_pkg::cell_ctl_t ctl,
  input  logic                sel,
  input  tdpb_pkg::stamp_t    load_data,
  input  tdpb_pkg::stamp_t    right_data,
  output tdpb_pkg::stamp_t    q
);

  tdpb_pkg::stamp_t data_r;
  tdpb_pkg::stamp_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = right_data;
    end else if (ctl.load && sel) begin
      data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== design/tdpb_ctrl.sv =====
module tdpb_ctrl #(
  parameter int DEPTH = 1024,
  parameter int CNT_W = 11,
  parameter int IDX_W = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tdpb_pkg::ARR_W-1:0]    arrive_tick,
  input  logic [tdpb_pkg::PROC_W-1:0]   work_ticks,
  input  logic                          cfg_we,
  input  logic [tdpb_pkg::SIZE_W-1:0]   cfg_data,
  input  tdpb_pkg::stamp_t              head_q,
  output tdpb_pkg::cell_ctl_t           cell_ctl,
  output logic [IDX_W-1:0]              load_idx,
  output tdpb_pkg::stamp_t              load_data,
  output logic                          out_valid,
  output logic                          out_dropped,
  output tdpb_pkg::stamp_t              out_begin_tick
);

  localparam int CMP_W = (CNT_W > tdpb_pkg::SIZE_W) ? CNT_W : tdpb_pkg::SIZE_W;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RETIRE = 1'b1;

  logic                          state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [tdpb_pkg::SIZE_W-1:0]   size_r, size_nxt;
  logic [tdpb_pkg::ARR_W-1:0]    arr_r;
  logic [tdpb_pkg::PROC_W-1:0]   proc_r;
  tdpb_pkg::stamp_t              last_r;
  logic                          valid_r;
  logic                          dropped_r;
  tdpb_pkg::stamp_t              start_r;

  logic                          accept;
  logic                          retire;
  logic                          decide;
  logic                          empty;
  logic                          room;
  logic                          take;
  tdpb_pkg::stamp_t              start_sel;
  logic [tdpb_pkg::TIME_W:0]     sum;
  tdpb_pkg::stamp_t              fin;

  always_comb begin
    accept    = start && (state_r == ST_IDLE);
    empty     = (count_r == '0);
    retire    = (state_r == ST_RETIRE) && !empty &&
                (head_q <= tdpb_pkg::TIME_W'(arr_r));
    decide    = (state_r == ST_RETIRE) && !retire;
    room      = (CMP_W'(count_r) < CMP_W'(size_r)) && (count_r != CNT_W'(DEPTH));
    take      = decide && (empty || room);
    start_sel = empty ? tdpb_pkg::TIME_W'(arr_r) : last_r;
    sum       = {1'b0, start_sel} + (tdpb_pkg::TIME_W + 1)'(proc_r);
    fin       = sum[tdpb_pkg::TIME_W] ? tdpb_pkg::TIME_MAX : sum[tdpb_pkg::TIME_W-1:0];

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (decide) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    count_nxt = count_r;
    if (retire) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (take) begin
      count_nxt = count_r + CNT_W'(1);
    end

    size_nxt = cfg_we ? cfg_data : size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      size_r  <= tdpb_pkg::SIZE_RST;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      size_r  <= size_nxt;
      valid_r <= decide;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arr_r  <= arrive_tick;
      proc_r <= work_ticks;
    end
    if (take) begin
      last_r <= fin;
    end
    if (decide) begin
      dropped_r <= !take;
      start_r   <= take ? start_sel : '0;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign cell_ctl.shift = retire;
  assign cell_ctl.load  = take;
  assign load_idx       = count_r[IDX_W-1:0];
  assign load_data      = fin;
  assign out_valid      = valid_r;
  assign out_dropped    = dropped_r;
  assign out_begin_tick = start_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int RING_DEPTH = 1024;
  localparam int RANDOM_PACKETS = 1250;
  localparam logic [tdpb_pkg::ARR_W-1:0] CURSOR_CEIL = 32'hF000_0000;

  typedef enum logic [1:0] {
    OP_PACKET,
    OP_SET_SIZE,
    OP_HOLD
  } traffic_op_t;

  typedef struct {
    traffic_op_t                 op;
    logic [tdpb_pkg::ARR_W-1:0]  arrival;
    logic [tdpb_pkg::PROC_W-1:0] ptime;
    logic [tdpb_pkg::SIZE_W-1:0] size;
    int                          gap;
  } traffic_t;

  typedef struct packed {
    logic             dropped;
    tdpb_pkg::stamp_t begin_tick;
  } verdict_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [tdpb_pkg::ARR_W-1:0]  in_arrive_tick = '0;
  logic [tdpb_pkg::PROC_W-1:0] in_work_ticks = '0;
  logic                        cfg_we = 1'b0;
  logic [tdpb_pkg::SIZE_W-1:0] cfg_data = '0;
  logic                        out_valid;
  logic                        out_dropped;
  tdpb_pkg::stamp_t            out_begin_tick;

  traffic_t                    traffic_q[$];
  verdict_t                    verdict_q[$];
  tdpb_pkg::stamp_t            fin_times[$];
  logic [tdpb_pkg::SIZE_W-1:0] buf_limit = tdpb_pkg::SIZE_RST;
  int                          idle_left = 0;
  int                          errors = 0;

  tail_drop_packet_buffer_top #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_arrive_tick(in_arrive_tick),
    .in_work_ticks(in_work_ticks),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_dropped(out_dropped),
    .out_begin_tick(out_begin_tick)
  );

  always #10 clk = ~clk;

  // Retires expired finish times, then either queues the packet or drops it.
  function automatic verdict_t admit_packet(input logic [tdpb_pkg::ARR_W-1:0] arrival,
                                            input logic [tdpb_pkg::PROC_W-1:0] ptime);
    int                         cap;
    tdpb_pkg::stamp_t           start_at;
    logic [tdpb_pkg::TIME_W:0]  sum;
    verdict_t                   v;
    cap = (buf_limit < RING_DEPTH) ? int'(buf_limit) : RING_DEPTH;
    while (fin_times.size() > 0 && fin_times[0] <= tdpb_pkg::stamp_t'(arrival))
      void'(fin_times.pop_front());
    if (fin_times.size() == 0) begin
      start_at = tdpb_pkg::stamp_t'(arrival);
    end else if (fin_times.size() < cap) begin
      start_at = fin_times[$];
    end else begin
      v.dropped = 1'b1;
      v.begin_tick = '0;
      return v;
    end
    sum = {1'b0, start_at} + (tdpb_pkg::TIME_W + 1)'(ptime);
    fin_times.insert(fin_times.size(),
                     (sum > {1'b0, tdpb_pkg::TIME_MAX}) ? tdpb_pkg::TIME_MAX
                                                         : sum[tdpb_pkg::TIME_W-1:0]);
    v.dropped = 1'b0;
    v.begin_tick = start_at;
    return v;
  endfunction

  function automatic void add_packet(input logic [tdpb_pkg::ARR_W-1:0] arrival,
                                     input logic [tdpb_pkg::PROC_W-1:0] ptime,
                                     input int gap);
    traffic_t t;
    t.op = OP_PACKET;
    t.arrival = arrival;
    t.ptime = ptime;
    t.size = '0;
    t.gap = gap;
    traffic_q.insert(traffic_q.size(), t);
  endfunction

  function automatic void add_control(input traffic_op_t op,
                                      input logic [tdpb_pkg::SIZE_W-1:0] size);
    traffic_t t;
    t.op = op;
    t.arrival = '0;
    t.ptime = '0;
    t.size = size;
    t.gap = 0;
    traffic_q.insert(traffic_q.size(), t);
  endfunction

  function automatic logic [tdpb_pkg::SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return 11'd1;
      2: return 11'd2047;
      3: return 11'd1024;
      4: return tdpb_pkg::SIZE_W'($urandom_range(1025, 2046));
      default: return tdpb_pkg::SIZE_W'($urandom_range(2, 12));
    endcase
  endfunction

  always @(posedge clk) begin
    logic go;
    logic we;
    go = 1'b0;
    we = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      cfg_data <= '0;
      in_arrive_tick <= '0;
      in_work_ticks <= '0;
      idle_left = 0;
    end else begin
      if (cfg_we)
        buf_limit = cfg_data;
      if (start && !busy) begin
        verdict_q.insert(verdict_q.size(), admit_packet(in_arrive_tick, in_work_ticks));
        void'(traffic_q.pop_front());
        idle_left = (traffic_q.size() != 0) ? traffic_q[0].gap : 0;
      end
      if (traffic_q.size() != 0) begin
        case (traffic_q[0].op)
          OP_PACKET: begin
            if (idle_left > 0)
              idle_left--;
            else
              go = 1'b1;
          end
          OP_SET_SIZE: begin
            if (verdict_q.size() == 0 && !busy && !out_valid && !cfg_we) begin
              we = 1'b1;
              cfg_data <= traffic_q[0].size;
              void'(traffic_q.pop_front());
              idle_left = (traffic_q.size() != 0) ? traffic_q[0].gap : 0;
            end
          end
          default: begin
            if (verdict_q.size() == 0 && !busy && !out_valid) begin
              void'(traffic_q.pop_front());
              idle_left = (traffic_q.size() != 0) ? traffic_q[0].gap : 0;
            end
          end
        endcase
      end
      start <= go;
      cfg_we <= we;
      if (go) begin
        in_arrive_tick <= traffic_q[0].arrival;
        in_work_ticks <= traffic_q[0].ptime;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with no packet outstanding");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_dropped);
          errors++;
        end
        if (out_begin_tick !== want.begin_tick) begin
          $error("begin_tick: expected %0d, got %0d", want.begin_tick, out_begin_tick);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [tdpb_pkg::ARR_W-1:0]  cursor;
    logic [tdpb_pkg::ARR_W-1:0]  arrival;
    logic [tdpb_pkg::ARR_W-1:0]  jump;
    logic [tdpb_pkg::PROC_W-1:0] ptime;
    int                          n_rand;
    int                          plen;
    int                          k;
    int                          r;
    int                          gap;
    bit                          quiet;
    bit                          hold_mid;

    add_packet(32'd0, 16'd0, 0);
    add_packet(32'd0, 16'hFFFF, 0);
    add_packet(32'd0, 16'hFFFF, 0);
    add_packet(32'd10, 16'd1, 0);
    add_packet(32'd10, 16'hAAAA, 0);
    add_packet(32'd5, 16'h5555, 0);
    add_control(OP_HOLD, '0);
    add_control(OP_SET_SIZE, 11'd1);
    add_packet(32'd400000, 16'd100, 0);
    add_packet(32'd400050, 16'd5, 0);
    add_packet(32'd400100, 16'd7, 0);
    add_control(OP_SET_SIZE, 11'd0);
    add_packet(32'd400100, 16'd3, 0);
    add_packet(32'd400107, 16'd4, 0);
    add_control(OP_SET_SIZE, 11'd2047);
    add_packet(32'd400107, 16'hFFFF, 0);
    add_packet(32'd100, 16'd1, 0);
    add_control(OP_SET_SIZE, 11'd2);
    add_packet(32'd600000, 16'h8000, 0);
    add_packet(32'd600000, 16'h8000, 0);
    add_packet(32'd600000, 16'h8000, 0);

    cursor = 32'd800000;
    n_rand = 0;
    while (n_rand < RANDOM_PACKETS) begin
      add_control(OP_SET_SIZE, pick_size());
      jump = $urandom_range(0, 300_000_000);
      if (cursor < CURSOR_CEIL - jump)
        cursor = cursor + jump;
      plen = $urandom_range(30, 80);
      quiet = ($urandom_range(0, 3) == 0);
      hold_mid = ($urandom_range(0, 5) == 0);
      for (k = 0; k < plen; k++) begin
        if (hold_mid && k == plen / 2)
          add_control(OP_HOLD, '0);
        r = $urandom_range(0, 99);
        arrival = cursor;
        if (r < 30) begin
          arrival = cursor;
        end else if (r < 70) begin
          cursor = cursor + $urandom_range(0, 40000);
          arrival = cursor;
        end else if (r < 90) begin
          cursor = cursor + $urandom_range(0, 140000);
          arrival = cursor;
        end else if (r < 95) begin
          arrival = cursor - ((cursor > 200000) ? $urandom_range(0, 200000)
                                                : $urandom_range(0, cursor));
        end else begin
          cursor = cursor + $urandom_range(0, 2_000_000);
          arrival = cursor;
        end
        r = $urandom_range(0, 19);
        ptime = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                tdpb_pkg::PROC_W'($urandom_range(0, 65535));
        gap = 0;
        if (!quiet && n_rand < RANDOM_PACKETS - 150 && $urandom_range(0, 3) == 0)
          gap = $urandom_range(1, 18);
        add_packet(arrival, ptime, gap);
        n_rand++;
      end
    end

    // The top of the arrival range is left to the very end, as nothing queued
    // after it could ever retire.
    add_control(OP_SET_SIZE, 11'd3);
    add_packet(32'hFFFF_FFFF, 16'hFFFF, 0);
    add_packet(32'hFFFF_FFFF, 16'd0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (traffic_q.size() != 0 || verdict_q.size() != 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
